/* sv/b64lw_pkg.sv */
// Shared types, constants and character mapping for the base64 line-wrap encoder.
`default_nettype none

package b64lw_pkg;

  localparam logic [7:0] WRAP_LIMIT_RESET = 8'd76;
  localparam logic [7:0] CHAR_NEWLINE     = 8'h0A;
  localparam logic [7:0] CHAR_PAD         = 8'h3D;
  localparam logic [8:0] GROUP_CHARS      = 9'd4;

  localparam int BURST_MAX = 5;
  localparam logic [2:0] CNT_NONE  = 3'd0;
  localparam logic [2:0] CNT_ONE   = 3'd1;
  localparam logic [2:0] CNT_GROUP = 3'd4;
  localparam logic [2:0] CNT_WRAP  = 3'd5;

  // Characters caused by one input byte, first character in slot 0.
  typedef struct packed {
    logic [BURST_MAX-1:0][7:0] chars;
    logic [2:0]                cnt;
  } b64lw_burst_t;

  // Map a 6-bit value to its standard base64 character.
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/b64lw_enc.sv */
// Message state and group encoding: turns one accepted byte into a character burst.
`default_nettype none

module b64lw_enc
  import b64lw_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [7:0]   cfg_data,
  input  wire logic         accept,
  input  wire logic [7:0]   data_byte,
  input  wire logic         end_of_message,
  output b64lw_burst_t      burst
);

  logic [7:0] limit;
  logic [7:0] held0;
  logic [7:0] held1;
  logic [1:0] held_count;
  logic [7:0] line_count;

  logic [1:0] held_count_next;
  logic [7:0] line_count_next;
  logic [7:0] g0, g1, g2;
  logic       pad2, pad3;
  logic [23:0] w;
  logic [8:0] sum;

  always_comb begin
    held_count_next = held_count;
    line_count_next = line_count;
    g0   = held0;
    g1   = held1;
    g2   = data_byte;
    pad2 = 1'b0;
    pad3 = 1'b0;
    sum  = {1'b0, line_count} + GROUP_CHARS;
    burst.cnt = CNT_NONE;

    if (held_count == 2'd2) begin
      burst.cnt = CNT_GROUP;
      held_count_next = 2'd0;
      if (sum > {1'b0, limit}) begin
        burst.cnt = CNT_WRAP;
        line_count_next = 8'd0;
      end else begin
        line_count_next = sum[7:0];
      end
    end else begin
      held_count_next = held_count + 2'd1;
      g2   = 8'd0;
      pad3 = 1'b1;
      if (held_count == 2'd0) begin
        g0   = data_byte;
        g1   = 8'd0;
        pad2 = 1'b1;
      end else begin
        g1 = data_byte;
      end
      if (end_of_message) begin
        burst.cnt = CNT_GROUP;
      end
    end

    if (end_of_message) begin
      held_count_next = 2'd0;
      line_count_next = 8'd0;
    end

    w = {g0, g1, g2};
    burst.chars[0] = b64_char(w[23:18]);
    burst.chars[1] = b64_char(w[17:12]);
    burst.chars[2] = pad2 ? CHAR_PAD : b64_char(w[11:6]);
    burst.chars[3] = pad3 ? CHAR_PAD : b64_char(w[5:0]);
    burst.chars[4] = CHAR_NEWLINE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit      <= WRAP_LIMIT_RESET;
      held_count <= 2'd0;
      line_count <= 8'd0;
      held0      <= 8'd0;
      held1      <= 8'd0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_data;
      end
      if (accept) begin
        held_count <= held_count_next;
        line_count <= line_count_next;
        if (held_count == 2'd0) begin
          held0 <= data_byte;
        end else if (held_count == 2'd1) begin
          held1 <= data_byte;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* sv/b64lw_ser.sv */
// Burst register that hands out one character per cycle while out_ready is high.
`default_nettype none

module b64lw_ser
  import b64lw_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire b64lw_burst_t burst,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [7:0]        out_char,
  output logic              last_of_run
);

  logic [BURST_MAX-1:0][7:0] chars;
  logic [2:0]                cnt;
  logic                      pop;

  assign out_valid   = (cnt != CNT_NONE);
  assign out_char    = chars[0];
  assign last_of_run = (cnt == CNT_ONE);
  assign pop         = out_valid && out_ready;
  // Take a new request when empty or when the last character leaves now.
  assign in_ready    = (cnt == CNT_NONE) || (last_of_run && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= CNT_NONE;
    end else if (in_valid && in_ready) begin
      cnt <= burst.cnt;
    end else if (pop) begin
      cnt <= cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      chars <= burst.chars;
    end else if (pop) begin
      chars <= {8'h00, chars[BURST_MAX-1:1]};
    end
  end

endmodule

`default_nettype wire

/* sv/base64_stream_line_wrap_top.sv */
// Top level of the streaming base64 encoder with line wrapping.
//
// Input channel (in_valid/in_ready, data_byte, end_of_message): one message
// byte per request. Output channel (out_valid/out_ready, out_char,
// last_of_run): one character per request; last_of_run marks the final
// character caused by an input byte.
// Every third byte of a message yields four base64 characters, plus a newline
// when line count plus four passes wrap_limit. A byte flagged end_of_message
// closes a partial group with '=' padding and clears the message state.
// The first character of a byte is offered in the cycle after the byte is
// accepted. The output side moves one character per cycle while out_ready is
// high, so a byte yielding characters holds the input off until its last one
// leaves; a byte yielding nothing leaves the input ready. Full groups average
// four characters per three bytes, up to five for a wrapping group.
// A new byte is taken in the same cycle the last character of the previous
// burst leaves, so back-to-back operation has no bubble.
// Reset (rst, synchronous) empties the burst register, clears held bytes and
// the line counter, and loads wrap_limit with 76. cfg_we writes wrap_limit.
// When the receiver stalls, the current character holds and input waits.
`default_nettype none

module base64_stream_line_wrap_top
  import b64lw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] wrap_limit,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_message,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char,
  output logic            last_of_run
);

  b64lw_burst_t burst;
  logic         accept;

  // A request is taken only when both sides of the input handshake agree.
  assign accept = in_valid && in_ready;

  // Message state and the encoding of one byte into a burst.
  b64lw_enc u_enc (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (wrap_limit),
    .accept         (accept),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .burst          (burst)
  );

  // Burst register: hold the characters and drain them one per cycle while out_ready is high.
  b64lw_ser u_ser (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .burst       (burst),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .last_of_run (last_of_run)
  );

  // Never overwrite a burst that still has characters waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    accept |-> (!out_valid || (out_ready && last_of_run)))
    else $error("input taken while characters still pending");

  // A burst drains without gaps until its last character.
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_of_run) |=> out_valid)
    else $error("burst ended before its last character");

  // A newline only ever closes a burst.
  a_newline_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_char == CHAR_NEWLINE)) |-> last_of_run)
    else $error("newline not at end of burst");

endmodule

`default_nettype wire

/* tb/sv/base64_stream_line_wrap_top_tb.sv */
// Self-checking testbench for the streaming base64 encoder with line wrapping.
`default_nettype none

module base64_stream_line_wrap_top_tb;
  import b64lw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles to wait after the last character before the block counts as idle.
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_BYTES   = 130;
  localparam int MAX_REPORTS   = 10;

  // Standard alphabet, character 0 in the top byte.
  localparam logic [511:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_rec_t;

  // One directed step: either a byte request or a new wrap limit.
  // Where typed is set, the characters it must cause are spelled out here.
  typedef struct {
    bit          is_cfg;
    logic [7:0]  value;
    logic        eom;
    bit          typed;
    int          n_typed;
    logic [39:0] typed_chars;
  } step_row_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [7:0] wrap_limit;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       end_of_message;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_char;
  logic       last_of_run;

  // Encoder state as the testbench sees it.
  logic [7:0] line_limit;
  logic [7:0] held [2];
  logic [1:0] held_cnt;
  logic [7:0] line_cnt;

  logic [7:0] new_chars [$];      // characters caused by the byte just taken
  char_rec_t  pending_chars [$];  // characters still owed by the block

  int send_idle;
  int recv_idle;
  int err_count;

  step_row_t directed_rows [27];

  base64_stream_line_wrap_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .wrap_limit     (wrap_limit),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .last_of_run    (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [7:0] b64_digit(input logic [5:0] v);
    return B64_ALPHABET[8 * (63 - int'(v)) +: 8];
  endfunction

  // Append the four characters of one group; nvalid counts the real bytes.
  task automatic push_group(input logic [23:0] w, input int nvalid);
    new_chars.push_back(b64_digit(w[23:18]));
    new_chars.push_back(b64_digit(w[17:12]));
    new_chars.push_back(nvalid >= 2 ? b64_digit(w[11:6]) : CHAR_PAD);
    new_chars.push_back(nvalid >= 3 ? b64_digit(w[5:0]) : CHAR_PAD);
  endtask

  // Advance the encoder state by one byte and collect the characters it causes.
  task automatic encode_byte(input logic [7:0] b, input logic e);
    logic [8:0] sum;
    new_chars.delete();
    if (held_cnt >= 2'd2) begin
      push_group({held[0], held[1], b}, 3);
      sum = {1'b0, line_cnt} + GROUP_CHARS;
      // Compare at full width so a high limit never sees a wrapped count.
      if (sum > {1'b0, line_limit}) begin
        new_chars.push_back(CHAR_NEWLINE);
        line_cnt = 8'd0;
      end else begin
        line_cnt = sum[7:0];
      end
      held_cnt = 2'd0;
    end else begin
      held[held_cnt[0]] = b;
      held_cnt = held_cnt + 2'd1;
      // Close a partial group with padding, never with a newline.
      if (e) begin
        push_group({held[0], (held_cnt == 2'd2) ? held[1] : 8'h00, 8'h00}, int'(held_cnt));
      end
    end
    if (e) begin
      held_cnt = 2'd0;
      line_cnt = 8'd0;
    end
  endtask

  // Offer one byte request, hold it until taken, then book what it owes.
  task automatic push_byte(input logic [7:0] b, input logic e, input bit typed,
                           input int n_typed, input logic [39:0] typed_chars);
    char_rec_t rec;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    data_byte      <= b;
    end_of_message <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    encode_byte(b, e);
    if (typed) begin
      new_chars.delete();
      for (int i = 0; i < n_typed; i++) begin
        new_chars.push_back(typed_chars[8 * (n_typed - 1 - i) +: 8]);
      end
    end
    foreach (new_chars[i]) begin
      rec.ch   = new_chars[i];
      rec.last = (i == new_chars.size() - 1);
      pending_chars.push_back(rec);
    end
  endtask

  // Drop valid and wait until every owed character has left the block.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    drain();
    @(negedge clk);
    cfg_we     <= 1'b1;
    wrap_limit <= v;
    @(negedge clk);
    cfg_we     <= 1'b0;
    line_limit = v;
  endtask

  // Receiver: stall at random, and hold ready low during reset.
  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(0, 99) >= recv_idle);
  end

  // Check every accepted character against the oldest one owed.
  always @(posedge clk) begin : check_out
    char_rec_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        if (err_count < MAX_REPORTS) begin
          $display("unexpected character %h last %b", out_char, last_of_run);
        end
        err_count++;
      end else begin
        want = pending_chars.pop_front();
        if (out_char !== want.ch || last_of_run !== want.last) begin
          if (err_count < MAX_REPORTS) begin
            $display("mismatch: expected char %h last %b, got char %h last %b",
                     want.ch, want.last, out_char, last_of_run);
          end
          err_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int sent;
    int len;
    bit first_msg;

    rst            = 1'b1;
    cfg_we         = 1'b0;
    wrap_limit     = WRAP_LIMIT_RESET;
    in_valid       = 1'b0;
    data_byte      = 8'h00;
    end_of_message = 1'b0;
    out_ready      = 1'b0;
    err_count      = 0;
    line_limit     = WRAP_LIMIT_RESET;
    held[0]        = 8'h00;
    held[1]        = 8'h00;
    held_cnt       = 2'd0;
    line_cnt       = 8'd0;
    send_idle      = 37;
    recv_idle      = 65;

    directed_rows = '{
      // after reset: two bytes held, the third releases the all-zero group
      '{0, 8'h00, 1'b0, 1, 0, 40'd0},
      '{0, 8'h00, 1'b0, 1, 0, 40'd0},
      '{0, 8'h00, 1'b0, 1, 4, "AAAA"},
      // all-ones group
      '{0, 8'hFF, 1'b0, 1, 0, 40'd0},
      '{0, 8'hFF, 1'b0, 1, 0, 40'd0},
      '{0, 8'hFF, 1'b0, 1, 4, "////"},
      // lone byte closes the message: two pads
      '{0, 8'hFF, 1'b1, 1, 4, "/w=="},
      // two bytes close the message: one pad
      '{0, 8'hFF, 1'b0, 1, 0, 40'd0},
      '{0, 8'hFF, 1'b1, 1, 4, "//8="},
      // full group on the closing byte, nothing for the empty remainder
      '{0, 8'h4D, 1'b0, 1, 0, 40'd0},
      '{0, 8'h61, 1'b0, 1, 0, 40'd0},
      '{0, 8'h6E, 1'b1, 1, 4, "TWFu"},
      // zero limit: every group wraps
      '{1, 8'd0,  1'b0, 0, 0, 40'd0},
      '{0, 8'h00, 1'b0, 0, 0, 40'd0},
      '{0, 8'h00, 1'b0, 0, 0, 40'd0},
      '{0, 8'h00, 1'b0, 1, 5, "AAAA\n"},
      // build up eight characters on the line
      '{1, 8'd76, 1'b0, 0, 0, 40'd0},
      '{0, 8'h80, 1'b0, 0, 0, 40'd0},
      '{0, 8'h01, 1'b0, 0, 0, 40'd0},
      '{0, 8'h7F, 1'b0, 0, 0, 40'd0},
      '{0, 8'hC3, 1'b0, 0, 0, 40'd0},
      '{0, 8'h3C, 1'b0, 0, 0, 40'd0},
      '{0, 8'h99, 1'b0, 0, 0, 40'd0},
      // lower the limit mid-line; the closing group wraps and ends the message
      '{1, 8'd3,  1'b0, 0, 0, 40'd0},
      '{0, 8'hAA, 1'b0, 0, 0, 40'd0},
      '{0, 8'h55, 1'b0, 0, 0, 40'd0},
      '{0, 8'h0F, 1'b1, 0, 0, 40'd0}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        write_limit(directed_rows[i].value);
      end else begin
        push_byte(directed_rows[i].value, directed_rows[i].eom, directed_rows[i].typed,
                  directed_rows[i].n_typed, directed_rows[i].typed_chars);
      end
    end

    // Random messages in three idling phases, each with its own limit.
    for (int p = 0; p < 3; p++) begin
      send_idle = (p == 0) ? 37 : (p == 1) ? 65 : 0;
      recv_idle = (p == 0) ? 65 : (p == 1) ? 37 : 0;
      case (p)
        0: write_limit(8'($urandom_range(0, 252)));
        1: write_limit(8'd252);
        default: write_limit(8'($urandom_range(0, 24)));
      endcase
      sent      = 0;
      first_msg = 1'b1;
      while (sent < PHASE_BYTES) begin
        // At the top limit, open with a message long enough to wrap once.
        if (first_msg && p == 1) begin
          len = $urandom_range(200, 230);
        end else if ($urandom_range(0, 3) == 0) begin
          len = $urandom_range(16, 60);
        end else begin
          len = $urandom_range(1, 12);
        end
        first_msg = 1'b0;
        for (int k = 0; k < len; k++) begin
          push_byte(8'($urandom_range(0, 255)), k == len - 1, 0, 0, 40'd0);
        end
        sent += len;
        // Now and then hold the sender until the output side catches up.
        if ($urandom_range(0, 19) == 0) begin
          drain();
        end
      end
    end

    drain();
    if (err_count == 0 && pending_chars.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
